@@ rtl/core/qei_pkg.sv @@
// Shared constants and types for the quaternion Euler integrator.
package qei_pkg;

  localparam int unsigned QUAT_WIDTH_DEF = 32;
  localparam int unsigned OMEGA_WIDTH    = 32;
  localparam int unsigned STEP_WIDTH     = 32;
  // increment = p * dt / 2 lands at F+49 fraction bits
  localparam int unsigned STEP_SHIFT     = 49;
  // stepped components keep 14 extra integer bits
  localparam int unsigned MID_EXTRA      = 14;

  localparam logic [STEP_WIDTH-1:0] STEP_TIME_RESET = 32'd429497;

  typedef struct packed {
    logic valid;
    logic zero;
  } pipe_ctl_t;

endpackage

@@ rtl/core/qei_step.sv @@
// Hamilton product, Euler increment and saturation of the stepped quaternion.
module qei_step #(
  parameter int unsigned QW = qei_pkg::QUAT_WIDTH_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         adv_i,
  input  logic                                         valid_i,
  input  logic [qei_pkg::STEP_WIDTH-1:0]               step_time_i,
  input  logic signed [QW-1:0]                         quat_i  [4],
  input  logic signed [qei_pkg::OMEGA_WIDTH-1:0]       omega_i [3],
  output logic                                         valid_o,
  output logic signed [QW+qei_pkg::MID_EXTRA-1:0]      s_o     [4]
);

  localparam int unsigned OW   = qei_pkg::OMEGA_WIDTH;
  localparam int unsigned SW   = qei_pkg::STEP_WIDTH;
  localparam int unsigned PW   = QW + OW;       // one product
  localparam int unsigned PSW  = PW + 2;        // sum of three products
  localparam int unsigned HW   = PSW - SW + SW + 1; // high part times dt
  localparam int unsigned LW   = 2 * SW;        // low part times dt
  localparam int unsigned FW   = PSW + SW + 1;  // full p * dt
  localparam int unsigned IW   = FW - qei_pkg::STEP_SHIFT;
  localparam int unsigned SUMW = IW + 1;
  localparam int unsigned NW   = QW + qei_pkg::MID_EXTRA;

  localparam logic signed [NW-1:0] S_MAX = {1'b0, {(NW-1){1'b1}}};
  localparam logic signed [NW-1:0] S_MIN = {1'b1, {(NW-1){1'b0}}};

  function automatic logic signed [PW-1:0] smul(logic signed [QW-1:0] a,
                                                logic signed [OW-1:0] b);
    logic signed [PW-1:0] ae;
    logic signed [PW-1:0] be;
    ae = PW'(a);
    be = PW'(b);
    return ae * be;
  endfunction

  logic [3:0] v_q;

  logic signed [PW-1:0]  prod_q [12];
  logic signed [PSW-1:0] p_q    [4];
  logic signed [HW-1:0]  hi_q   [4];
  logic [LW-1:0]         lo_q   [4];
  logic signed [QW-1:0]  q1_q   [4];
  logic signed [QW-1:0]  q2_q   [4];
  logic signed [QW-1:0]  q3_q   [4];
  logic signed [NW-1:0]  s_q    [4];

  logic signed [NW-1:0]  s_d    [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  // stage 1: the twelve partial products of q * (0, omega)
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q[0]  <= smul(quat_i[1], omega_i[0]);
      prod_q[1]  <= smul(quat_i[2], omega_i[1]);
      prod_q[2]  <= smul(quat_i[3], omega_i[2]);
      prod_q[3]  <= smul(quat_i[0], omega_i[0]);
      prod_q[4]  <= smul(quat_i[2], omega_i[2]);
      prod_q[5]  <= smul(quat_i[3], omega_i[1]);
      prod_q[6]  <= smul(quat_i[0], omega_i[1]);
      prod_q[7]  <= smul(quat_i[1], omega_i[2]);
      prod_q[8]  <= smul(quat_i[3], omega_i[0]);
      prod_q[9]  <= smul(quat_i[0], omega_i[2]);
      prod_q[10] <= smul(quat_i[2], omega_i[0]);
      prod_q[11] <= smul(quat_i[1], omega_i[1]);
      q1_q       <= quat_i;
    end
  end

  // stage 2: product components, exact
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_q[0] <= -PSW'(prod_q[0]) - PSW'(prod_q[1]) - PSW'(prod_q[2]);
      p_q[1] <=  PSW'(prod_q[3]) + PSW'(prod_q[4]) - PSW'(prod_q[5]);
      p_q[2] <=  PSW'(prod_q[6]) - PSW'(prod_q[7]) + PSW'(prod_q[8]);
      p_q[3] <=  PSW'(prod_q[9]) - PSW'(prod_q[10]) + PSW'(prod_q[11]);
      q2_q   <= q1_q;
    end
  end

  // stage 3: p * dt split into a signed high and an unsigned low partial
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 4; i++) begin
        hi_q[i] <= HW'($signed(p_q[i][PSW-1:SW])) * HW'($signed({1'b0, step_time_i}));
        lo_q[i] <= LW'(p_q[i][SW-1:0]) * LW'(step_time_i);
      end
      q3_q <= q2_q;
    end
  end

  // stage 4: recombine, floor shift, add q and saturate
  always_comb begin
    logic [FW-1:0]         full;
    logic signed [SUMW-1:0] sum;
    logic [SUMW-NW:0]      upper;
    for (int i = 0; i < 4; i++) begin
      full  = (FW'(hi_q[i]) << SW) + FW'(lo_q[i]);
      sum   = SUMW'($signed(full[FW-1:qei_pkg::STEP_SHIFT])) + SUMW'(q3_q[i]);
      upper = sum[SUMW-1:NW-1];
      if ((&upper) || !(|upper)) begin
        s_d[i] = sum[NW-1:0];
      end else if (sum[SUMW-1]) begin
        s_d[i] = S_MIN;
      end else begin
        s_d[i] = S_MAX;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s_q <= s_d;
    end
  end

  assign valid_o = v_q[3];
  assign s_o     = s_q;

endmodule

@@ rtl/core/qei_sqrt.sv @@
// Sum of squares and a bit-per-stage integer square root pipeline.
module qei_sqrt #(
  parameter int unsigned QW = qei_pkg::QUAT_WIDTH_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    adv_i,
  input  logic                                    valid_i,
  input  logic signed [QW+qei_pkg::MID_EXTRA-1:0] s_i    [4],
  output qei_pkg::pipe_ctl_t                      ctl_o,
  output logic [QW+qei_pkg::MID_EXTRA:0]          norm_o,
  output logic [QW+qei_pkg::MID_EXTRA-1:0]        mag_o  [4],
  output logic [3:0]                              neg_o
);

  localparam int unsigned NW  = QW + qei_pkg::MID_EXTRA;
  localparam int unsigned RW  = NW + 1;   // root bits
  localparam int unsigned DW  = 2 * RW;   // radicand bits
  // squares are built from half-width partial products
  localparam int unsigned LOW = (NW + 1) / 2;
  localparam int unsigned HIW = NW - LOW;

  logic                 va_q;
  logic [NW-1:0]        mag_a_q [4];
  logic [3:0]           neg_a_q;
  logic [2*LOW-1:0]     ll_a_q  [4];
  logic [HIW+LOW-1:0]   lh_a_q  [4];
  logic [2*HIW-1:0]     hh_a_q  [4];

  logic                 vs_q;
  logic [NW-1:0]        mag_s_q [4];
  logic [3:0]           neg_s_q;
  logic [2*NW-1:0]      sq_s_q  [4];

  logic                 vb_q;
  logic                 zero_b_q;
  logic [DW-1:0]        rad_b_q;
  logic [NW-1:0]        mag_b_q [4];
  logic [3:0]           neg_b_q;

  logic                 v_q    [1:RW];
  logic                 zero_q [1:RW];
  logic [RW:0]          rem_q  [1:RW];
  logic [RW-1:0]        root_q [1:RW];
  logic [DW-1:0]        rad_q  [1:RW];
  logic [NW-1:0]        mag_q  [1:RW][4];
  logic [3:0]           neg_q  [1:RW];

  logic [NW-1:0]        mag_d  [4];
  logic [DW-1:0]        n2_d;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_d[i] = s_i[i][NW-1] ? ($unsigned(~s_i[i]) + NW'(1)) : $unsigned(s_i[i]);
    end
  end

  assign n2_d = DW'(sq_s_q[0]) + DW'(sq_s_q[1]) + DW'(sq_s_q[2]) + DW'(sq_s_q[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vs_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
      vs_q <= va_q;
      vb_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 4; i++) begin
        mag_a_q[i] <= mag_d[i];
        neg_a_q[i] <= s_i[i][NW-1];
        ll_a_q[i]  <= (2*LOW)'(mag_d[i][LOW-1:0]) * (2*LOW)'(mag_d[i][LOW-1:0]);
        lh_a_q[i]  <= (HIW+LOW)'(mag_d[i][NW-1:LOW]) * (HIW+LOW)'(mag_d[i][LOW-1:0]);
        hh_a_q[i]  <= (2*HIW)'(mag_d[i][NW-1:LOW]) * (2*HIW)'(mag_d[i][NW-1:LOW]);
        sq_s_q[i]  <= ((2*NW)'(hh_a_q[i]) << (2*LOW)) +
                      ((2*NW)'(lh_a_q[i]) << (LOW+1)) + (2*NW)'(ll_a_q[i]);
      end
      mag_s_q  <= mag_a_q;
      neg_s_q  <= neg_a_q;
      rad_b_q  <= n2_d;
      zero_b_q <= (n2_d == '0);
      mag_b_q  <= mag_s_q;
      neg_b_q  <= neg_s_q;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_root
    logic           src_v;
    logic           src_zero;
    logic [RW:0]    src_rem;
    logic [RW-1:0]  src_root;
    logic [DW-1:0]  src_rad;
    logic [NW-1:0]  src_mag [4];
    logic [3:0]     src_neg;
    logic [RW+2:0]  cat;
    logic [RW+2:0]  trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign src_v    = vb_q;
      assign src_zero = zero_b_q;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_rad  = rad_b_q;
      assign src_mag  = mag_b_q;
      assign src_neg  = neg_b_q;
    end else begin : g_next
      assign src_v    = v_q[k];
      assign src_zero = zero_q[k];
      assign src_rem  = rem_q[k];
      assign src_root = root_q[k];
      assign src_rad  = rad_q[k];
      assign src_mag  = mag_q[k];
      assign src_neg  = neg_q[k];
    end

    assign cat   = {src_rem, src_rad[DW-1:DW-2]};
    assign trial = {1'b0, src_root, 2'b01};
    assign ge    = (cat >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        v_q[k+1] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k+1]  <= ge ? (RW+1)'(cat - trial) : cat[RW:0];
        root_q[k+1] <= {src_root[RW-2:0], ge};
        rad_q[k+1]  <= {src_rad[DW-3:0], 2'b00};
        zero_q[k+1] <= src_zero;
        mag_q[k+1]  <= src_mag;
        neg_q[k+1]  <= src_neg;
      end
    end
  end

  assign ctl_o.valid = v_q[RW];
  assign ctl_o.zero  = zero_q[RW];
  assign norm_o      = root_q[RW];
  assign mag_o       = mag_q[RW];
  assign neg_o       = neg_q[RW];

endmodule

@@ rtl/core/qei_div.sv @@
// Four restoring dividers in lockstep, one quotient bit per stage.
module qei_div #(
  parameter int unsigned QW = qei_pkg::QUAT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  qei_pkg::pipe_ctl_t                  ctl_i,
  input  logic [QW+qei_pkg::MID_EXTRA:0]      norm_i,
  input  logic [QW+qei_pkg::MID_EXTRA-1:0]    mag_i [4],
  input  logic [3:0]                          neg_i,
  output qei_pkg::pipe_ctl_t                  ctl_o,
  output logic [QW-2:0]                       quo_o [4],
  output logic [3:0]                          neg_o
);

  localparam int unsigned NW = QW + qei_pkg::MID_EXTRA;
  localparam int unsigned RW = NW + 1;
  localparam int unsigned QDW = QW - 1;   // quotient never exceeds 2^F
  localparam int unsigned STEPS = QDW;

  qei_pkg::pipe_ctl_t ctl_q  [1:STEPS];
  logic [RW-1:0]      norm_q [1:STEPS];
  logic [RW-1:0]      rem_q  [1:STEPS][4];
  logic [QDW-1:0]     quo_q  [1:STEPS][4];
  logic [3:0]         neg_q  [1:STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_div
    qei_pkg::pipe_ctl_t src_ctl;
    logic [RW-1:0]      src_norm;
    logic [3:0]         src_neg;
    logic [RW:0]        cat   [4];
    logic [QDW-1:0]     quo_s [4];
    logic [RW-1:0]      rem_d [4];
    logic [QDW-1:0]     quo_d [4];

    if (j == 0) begin : g_first
      // magnitude never exceeds the norm, so the first bit is 0 or 1
      assign src_ctl  = ctl_i;
      assign src_norm = norm_i;
      assign src_neg  = neg_i;
      always_comb begin
        for (int i = 0; i < 4; i++) begin
          cat[i]   = (RW+1)'(mag_i[i]);
          quo_s[i] = '0;
        end
      end
    end else begin : g_next
      assign src_ctl  = ctl_q[j];
      assign src_norm = norm_q[j];
      assign src_neg  = neg_q[j];
      always_comb begin
        for (int i = 0; i < 4; i++) begin
          cat[i]   = {rem_q[j][i], 1'b0};
          quo_s[i] = quo_q[j][i];
        end
      end
    end

    always_comb begin
      logic ge;
      for (int i = 0; i < 4; i++) begin
        ge       = (cat[i] >= (RW+1)'(src_norm));
        rem_d[i] = ge ? RW'(cat[i] - (RW+1)'(src_norm)) : cat[i][RW-1:0];
        quo_d[i] = {quo_s[i][QDW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[j+1] <= '0;
      end else if (adv_i) begin
        ctl_q[j+1] <= src_ctl;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        norm_q[j+1] <= src_norm;
        neg_q[j+1]  <= src_neg;
        rem_q[j+1]  <= rem_d;
        quo_q[j+1]  <= quo_d;
      end
    end
  end

  assign ctl_o = ctl_q[STEPS];
  assign quo_o = quo_q[STEPS];
  assign neg_o = neg_q[STEPS];

endmodule

@@ rtl/core/quaternion_euler_integrator_unit.sv @@
// Top level of the quaternion Euler integrator with its output register.
// Fully pipelined: one request is taken every cycle unless in_stall_o is
// raised. The pipeline depth is set by the square root, which resolves one
// root bit per stage (QUAT_WIDTH+15 stages), and the four dividers, one
// quotient bit per stage (QUAT_WIDTH-1 stages); product, step and sum of
// squares take seven stages, the output register one. While a result waits
// under out_stall_i the whole pipeline holds, and in_stall_o is raised.
// Results saturate; a stepped quaternion of zero norm returns zeros with
// zero_norm_o set. step_time must be written through cfg_we_i/cfg_data_i
// only while no request is in flight; the block does not enforce this.
module quaternion_euler_integrator_unit #(
  parameter int unsigned QUAT_WIDTH = qei_pkg::QUAT_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [qei_pkg::STEP_WIDTH-1:0]         cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [QUAT_WIDTH-1:0]           quat_w_i,
  input  logic signed [QUAT_WIDTH-1:0]           quat_x_i,
  input  logic signed [QUAT_WIDTH-1:0]           quat_y_i,
  input  logic signed [QUAT_WIDTH-1:0]           quat_z_i,
  input  logic signed [qei_pkg::OMEGA_WIDTH-1:0] omega_x_i,
  input  logic signed [qei_pkg::OMEGA_WIDTH-1:0] omega_y_i,
  input  logic signed [qei_pkg::OMEGA_WIDTH-1:0] omega_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [QUAT_WIDTH-1:0]           next_w_o,
  output logic signed [QUAT_WIDTH-1:0]           next_x_o,
  output logic signed [QUAT_WIDTH-1:0]           next_y_o,
  output logic signed [QUAT_WIDTH-1:0]           next_z_o,
  output logic                                   zero_norm_o
);

  localparam int unsigned QW  = QUAT_WIDTH;
  localparam int unsigned NW  = QW + qei_pkg::MID_EXTRA;
  localparam int unsigned RW  = NW + 1;
  localparam int unsigned QDW = QW - 1;
  localparam logic signed [QW-1:0] Q_ONE = QW'(1) << (QW - 2);

  logic [qei_pkg::STEP_WIDTH-1:0] step_time_q;

  logic                          adv;
  logic signed [QW-1:0]          quat  [4];
  logic signed [qei_pkg::OMEGA_WIDTH-1:0] omega [3];

  logic                          st_valid;
  logic signed [NW-1:0]          st_s [4];

  qei_pkg::pipe_ctl_t            rt_ctl;
  logic [RW-1:0]                 rt_norm;
  logic [NW-1:0]                 rt_mag [4];
  logic [3:0]                    rt_neg;

  qei_pkg::pipe_ctl_t            dv_ctl;
  logic [QDW-1:0]                dv_quo [4];
  logic [3:0]                    dv_neg;

  logic signed [QW-1:0]          res_d [4];
  logic signed [QW-1:0]          res_q [4];
  logic                          out_valid_q;
  logic                          zero_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  assign quat[0]  = quat_w_i;
  assign quat[1]  = quat_x_i;
  assign quat[2]  = quat_y_i;
  assign quat[3]  = quat_z_i;
  assign omega[0] = omega_x_i;
  assign omega[1] = omega_y_i;
  assign omega[2] = omega_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q <= qei_pkg::STEP_TIME_RESET;
    end else if (cfg_we_i) begin
      step_time_q <= cfg_data_i;
    end
  end

  qei_step #(.QW(QW)) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (in_valid_i),
    .step_time_i (step_time_q),
    .quat_i      (quat),
    .omega_i     (omega),
    .valid_o     (st_valid),
    .s_o         (st_s)
  );

  qei_sqrt #(.QW(QW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (st_valid),
    .s_i     (st_s),
    .ctl_o   (rt_ctl),
    .norm_o  (rt_norm),
    .mag_o   (rt_mag),
    .neg_o   (rt_neg)
  );

  qei_div #(.QW(QW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ctl_i  (rt_ctl),
    .norm_i (rt_norm),
    .mag_i  (rt_mag),
    .neg_i  (rt_neg),
    .ctl_o  (dv_ctl),
    .quo_o  (dv_quo),
    .neg_o  (dv_neg)
  );

  // quotient is at most 2^F, so restoring the sign cannot overflow
  always_comb begin
    logic [QW-1:0] mag;
    for (int i = 0; i < 4; i++) begin
      mag = QW'(dv_quo[i]);
      if (dv_ctl.zero) begin
        res_d[i] = '0;
      end else if (dv_neg[i]) begin
        res_d[i] = $signed(~mag + QW'(1));
      end else begin
        res_d[i] = $signed(mag);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q  <= res_d;
      zero_q <= dv_ctl.zero;
    end
  end

  assign out_valid_o = out_valid_q;
  assign next_w_o    = res_q[0];
  assign next_x_o    = res_q[1];
  assign next_y_o    = res_q[2];
  assign next_z_o    = res_q[3];
  assign zero_norm_o = zero_q;

`ifndef NO_ASSERTIONS
  a_zero_gives_zeros: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_norm_o |->
      next_w_o == '0 && next_x_o == '0 && next_y_o == '0 && next_z_o == '0)
    else $error("zero norm result with nonzero components");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      next_w_o <= Q_ONE && next_w_o >= -Q_ONE && next_x_o <= Q_ONE &&
      next_x_o >= -Q_ONE && next_y_o <= Q_ONE && next_y_o >= -Q_ONE &&
      next_z_o <= Q_ONE && next_z_o >= -Q_ONE)
    else $error("normalized component beyond one");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output register");
`endif

endmodule
